FILE: rtl/bsw_pkg.sv
package bsw_pkg;

   localparam int LANES  = 8;
   localparam int BYTE_W = 8;
   localparam int WORD_W = LANES * BYTE_W;

   // Odd-even transposition rounds, split evenly over the pipeline
   localparam int ROUNDS           = LANES;
   localparam int ROUNDS_PER_STAGE = 2;
   localparam int STAGES           = ROUNDS / ROUNDS_PER_STAGE;

   typedef logic [BYTE_W-1:0] lane_type;

   typedef struct packed {
      logic                valid;
      logic [WORD_W-1:0]   word;
   } stage_type;

endpackage

FILE: rtl/bsw_stage.sv
module bsw_stage (
   input  logic               clock,
   input  logic               reset,
   input  bsw_pkg::stage_type stage_in,
   output bsw_pkg::stage_type stage_out
);

   bsw_pkg::lane_type lane_a [bsw_pkg::LANES];
   bsw_pkg::lane_type lane_b [bsw_pkg::LANES];
   bsw_pkg::lane_type lane_c [bsw_pkg::LANES];

   logic                        valid_ff;
   logic [bsw_pkg::WORD_W-1:0]  word_ff;
   logic [bsw_pkg::WORD_W-1:0]  word_in;

   // Even round on pairs (0,1),(2,3)..., then odd round on (1,2),(3,4)...
   always_comb begin
      for (int k = 0; k < bsw_pkg::LANES; k++) begin
         lane_a[k] = stage_in.word[k*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W];
      end
      for (int k = 0; k < bsw_pkg::LANES; k++) begin
         lane_b[k] = lane_a[k];
      end
      for (int k = 0; k + 1 < bsw_pkg::LANES; k += 2) begin
         if (lane_a[k] > lane_a[k+1]) begin
            lane_b[k]   = lane_a[k+1];
            lane_b[k+1] = lane_a[k];
         end
      end
      for (int k = 0; k < bsw_pkg::LANES; k++) begin
         lane_c[k] = lane_b[k];
      end
      for (int k = 1; k + 1 < bsw_pkg::LANES; k += 2) begin
         if (lane_b[k] > lane_b[k+1]) begin
            lane_c[k]   = lane_b[k+1];
            lane_c[k+1] = lane_b[k];
         end
      end
      for (int k = 0; k < bsw_pkg::LANES; k++) begin
         word_in[k*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W] = lane_c[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.word  = word_ff;

endmodule

FILE: rtl/byte_sort_word64.sv
// Byte sorter for a 64-bit word.
//
// Input: a transfer takes place at a rising edge with start high and busy
// low. req_word_in carries eight unsigned bytes, byte 0 in bits 7:0.
// busy is always low, so a new word may be issued every cycle.
//
// Output: rsp_valid is high for exactly one cycle per transfer, with
// rsp_sorted_word holding the same bytes in ascending order, smallest in
// bits 7:0. Duplicates are kept.
//
// Throughput is one word per cycle. The sort is an eight-round odd-even
// transposition network cut into four register stages of two
// compare-exchange rounds each, and a word is registered in every stage
// on its way from the accepting edge to the result.
//
// Synchronous reset clears the stage valid bits, dropping any words in
// flight; no result appears for them. The receiver cannot stall, so no
// backpressure path exists and results leave in issue order.
module byte_sort_word64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_word_in,
   output logic        rsp_valid,
   output logic [63:0] rsp_sorted_word
);

   bsw_pkg::stage_type stage_link [bsw_pkg::STAGES+1];

   assign busy = 1'b0;

   assign stage_link[0].valid = start & ~busy;
   assign stage_link[0].word  = req_word_in;

   for (genvar s = 0; s < bsw_pkg::STAGES; s++) begin : g_stage
      bsw_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_link[s]),
         .stage_out (stage_link[s+1])
      );
   end

   assign rsp_valid       = stage_link[bsw_pkg::STAGES].valid;
   assign rsp_sorted_word = stage_link[bsw_pkg::STAGES].word;

endmodule

FILE: rtl/bsw_checker.sv
module bsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [63:0] req_word_in,
   input logic        rsp_valid,
   input logic [63:0] rsp_sorted_word
);

   logic                         ordered;
   logic [bsw_pkg::BYTE_W+2:0]   in_sum;
   logic [bsw_pkg::BYTE_W+2:0]   out_sum;

   always_comb begin
      ordered = 1'b1;
      for (int k = 0; k + 1 < bsw_pkg::LANES; k++) begin
         if (rsp_sorted_word[k*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W] >
             rsp_sorted_word[(k+1)*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W]) begin
            ordered = 1'b0;
         end
      end
   end

   // Sum the bytes on both sides; sorting only moves them around
   always_comb begin
      in_sum  = '0;
      out_sum = '0;
      for (int k = 0; k < bsw_pkg::LANES; k++) begin
         in_sum  = in_sum + {3'b000, req_word_in[k*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W]};
         out_sum = out_sum
                 + {3'b000, rsp_sorted_word[k*bsw_pkg::BYTE_W +: bsw_pkg::BYTE_W]};
      end
   end

   // Every accepted transfer yields a result at the pipeline output
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result missing four cycles after transfer");

   // No result without a matching earlier transfer
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##4 !rsp_valid)
      else $error("result without a matching transfer");

   // Results hold bytes in ascending order
   a_ordered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ordered)
      else $error("result bytes not ascending");

   // The bytes of a transfer reach the result unchanged in total
   a_bytes_kept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 (out_sum == $past(in_sum, 4)))
      else $error("result bytes differ from the transfer");

   // Reset flushes the pipeline
   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind byte_sort_word64 bsw_checker u_bsw_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_word_in     (req_word_in),
   .rsp_valid       (rsp_valid),
   .rsp_sorted_word (rsp_sorted_word)
);
